// ===== rtl/pal_pkg.sv =====
package pal_pkg;

   // Request codes.
   localparam logic [1:0] MODE_READ   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_BAD_POS = 2'd2;

   localparam int unsigned POS_W   = 5;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/pal_req_if.sv =====
interface pal_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           mode;
   logic [pal_pkg::POS_W-1:0]            position;
   logic signed [pal_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// ===== rtl/pal_rsp_if.sv =====
interface pal_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic signed [pal_pkg::VALUE_W-1:0]   read_value;
   logic [pal_pkg::COUNT_W-1:0]          count;
   logic                                 is_empty;
   logic                                 is_full;

   modport source (output valid, output status, output read_value, output count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input status, input read_value, input count,
                   input is_empty, input is_full, output ready);
endinterface

// ===== rtl/positional_array_list.sv =====
// Ordered list of up to DEPTH signed 32-bit values held packed in one single-port-write,
// one-read synchronous memory. A read passes the memory read register and then the result
// register. An insert at position p with n entries moves the n - p entries from p up by one
// place, and a remove moves the n - p - 1 entries above p down by one place: each cycle the
// memory reads one entry and writes back the entry read the cycle before. One request is in
// work at a time; the result sits in an output register, so a new request is taken while the
// previous result waits for its transfer. Refused requests (full on insert, bad position,
// unused mode) leave the list unchanged. The count output carries the low 5 bits of the
// entry count.
module positional_array_list #(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   pal_req_if.sink     req_ch,
   pal_rsp_if.source   rsp_ch
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned MW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

   pal_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                       count_ff, count_in;
   logic [1:0]                          op_ff, op_in;
   logic [1:0]                          status_ff, status_in;
   logic [AW-1:0]                       pos_ff, pos_in;
   logic [AW-1:0]                       addr_ff, addr_in;
   logic [AW-1:0]                       last_ff, last_in;
   logic signed [pal_pkg::VALUE_W-1:0]  val_ff, val_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic signed [pal_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [pal_pkg::COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                                rsp_empty_ff, rsp_empty_in;
   logic                                rsp_full_ff, rsp_full_in;

   // Memory ports.
   logic signed [pal_pkg::VALUE_W-1:0]  entries_ff [DEPTH];
   logic signed [pal_pkg::VALUE_W-1:0]  rd_data_ff;
   logic                                rd_en, wr_en;
   logic [AW-1:0]                       rd_addr, wr_addr;
   logic signed [pal_pkg::VALUE_W-1:0]  wr_data;

   logic          req_fire, slot_free;
   logic [MW-1:0] pos_w, cnt_w;
   logic [AW-1:0] pos_idx, cnt_m1_idx;
   logic [CW-1:0] cnt_m1;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign pos_w     = MW'(req_ch.position);
   assign cnt_w     = MW'(count_ff);
   assign pos_idx   = pos_w[AW-1:0];
   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m1_idx = cnt_m1[AW-1:0];

   assign req_ch.ready = (state_ff == pal_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   always_comb begin
      logic [CW-1:0] cnt_new;
      cnt_new       = count_ff;
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         pal_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_ch.mode;
               pos_in    = pos_idx;
               val_in    = req_ch.value;
               status_in = pal_pkg::STAT_BAD_POS;
               state_in  = pal_pkg::ST_FINISH;
               case (req_ch.mode)
                  pal_pkg::MODE_READ: begin
                     if (pos_w < cnt_w) begin
                        status_in = pal_pkg::STAT_DONE;
                        rd_en     = 1'b1;
                        rd_addr   = pos_idx;
                     end
                  end
                  pal_pkg::MODE_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = pal_pkg::STAT_FULL;
                     end else if (pos_w <= cnt_w) begin
                        status_in = pal_pkg::STAT_DONE;
                        if (pos_w < cnt_w) begin
                           // Move entries up starting from the last one.
                           rd_en    = 1'b1;
                           rd_addr  = cnt_m1_idx;
                           addr_in  = cnt_m1_idx;
                           state_in = pal_pkg::ST_SHIFT_UP;
                        end
                     end
                  end
                  pal_pkg::MODE_REMOVE: begin
                     if (pos_w < cnt_w) begin
                        status_in = pal_pkg::STAT_DONE;
                        if ((pos_w + MW'(1)) < cnt_w) begin
                           rd_en    = 1'b1;
                           rd_addr  = pos_idx + AW'(1);
                           addr_in  = pos_idx + AW'(1);
                           last_in  = cnt_m1_idx;
                           state_in = pal_pkg::ST_SHIFT_DOWN;
                        end
                     end
                  end
                  default: begin
                     status_in = pal_pkg::STAT_BAD_POS;
                  end
               endcase
            end
         end
         pal_pkg::ST_SHIFT_UP: begin
            // The entry read last cycle lands one place higher.
            wr_en   = 1'b1;
            wr_addr = addr_ff + AW'(1);
            if (addr_ff == pos_ff) begin
               state_in = pal_pkg::ST_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = addr_ff - AW'(1);
               addr_in = addr_ff - AW'(1);
            end
         end
         pal_pkg::ST_SHIFT_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff - AW'(1);
            if (addr_ff == last_ff) begin
               state_in = pal_pkg::ST_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = addr_ff + AW'(1);
               addr_in = addr_ff + AW'(1);
            end
         end
         pal_pkg::ST_FINISH: begin
            if (status_ff == pal_pkg::STAT_DONE && op_ff == pal_pkg::MODE_INSERT) begin
               cnt_new = count_ff + CW'(1);
            end else if (status_ff == pal_pkg::STAT_DONE && op_ff == pal_pkg::MODE_REMOVE) begin
               cnt_new = cnt_m1;
            end
            if (slot_free) begin
               if (status_ff == pal_pkg::STAT_DONE && op_ff == pal_pkg::MODE_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = pos_ff;
                  wr_data = val_ff;
               end
               count_in      = cnt_new;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = (status_ff == pal_pkg::STAT_DONE && op_ff == pal_pkg::MODE_READ)
                               ? rd_data_ff : '0;
               rsp_count_in  = pal_pkg::COUNT_W'(cnt_new);
               rsp_empty_in  = (cnt_new == '0);
               rsp_full_in   = (cnt_new == CW'(DEPTH));
               state_in      = pal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pal_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      pos_ff        <= pos_in;
      addr_ff       <= addr_in;
      last_ff       <= last_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.is_empty   = rsp_empty_ff;
   assign rsp_ch.is_full    = rsp_full_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_count_moves_at_finish: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && count_ff != $past(count_ff)) |-> $past(state_ff == pal_pkg::ST_FINISH))
      else $error("entry count changed outside the finish step");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pal_pkg::ST_FINISH && status_ff != pal_pkg::STAT_DONE)
      |=> count_ff == $past(count_ff))
      else $error("refused request changed the entry count");

   a_shift_up_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == pal_pkg::ST_SHIFT_UP |-> addr_ff >= pos_ff)
      else $error("upward move ran below the insert position");

   a_finish_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pal_pkg::ST_FINISH && slot_free) |=> rsp_valid_ff)
      else $error("finished request produced no result");

endmodule
